[src/cga_palette_quantizer_top_macros.svh]
// ----------------------------------------------------------------------------
// cga palette quantizer assertion macros
// shared checks written against the module's clk and arst_n
// ----------------------------------------------------------------------------
`ifndef CGA_PALETTE_QUANTIZER_TOP_MACROS_SVH
`define CGA_PALETTE_QUANTIZER_TOP_MACROS_SVH

// same-cycle implication, idle during reset
`define CGA_PQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, idle during reset
`define CGA_PQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/cga_pq_pkg.sv]
// ----------------------------------------------------------------------------
// cga palette quantizer package
// field widths, distance width and the fixed 16-entry palette
// ----------------------------------------------------------------------------
package cga_pq_pkg;

	localparam int COLOR_W  = 8;
	localparam int INDEX_W  = 4;
	localparam int SQ_W     = 2 * COLOR_W;
	// three squared 8-bit differences fit in 18 bits
	localparam int DIST_W   = SQ_W + 2;
	localparam int PAL_MAX  = 16;

	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [SQ_W-1:0]    sq_t;
	typedef logic [DIST_W-1:0]  dist_t;

	// initial best distance, 3 * 255^2
	localparam dist_t START_DIST = dist_t'(3 * 255 * 255);

	typedef struct packed {
		color_t red;
		color_t green;
		color_t blue;
	} rgb_t;

	// palette entries in index order
	localparam rgb_t CGA_PALETTE [PAL_MAX] = '{
		'{red: 8'd0,   green: 8'd0,   blue: 8'd0},
		'{red: 8'd0,   green: 8'd0,   blue: 8'd170},
		'{red: 8'd0,   green: 8'd170, blue: 8'd0},
		'{red: 8'd0,   green: 8'd170, blue: 8'd170},
		'{red: 8'd170, green: 8'd0,   blue: 8'd0},
		'{red: 8'd170, green: 8'd0,   blue: 8'd170},
		'{red: 8'd170, green: 8'd85,  blue: 8'd0},
		'{red: 8'd170, green: 8'd170, blue: 8'd170},
		'{red: 8'd85,  green: 8'd85,  blue: 8'd85},
		'{red: 8'd85,  green: 8'd85,  blue: 8'd255},
		'{red: 8'd85,  green: 8'd255, blue: 8'd85},
		'{red: 8'd85,  green: 8'd255, blue: 8'd255},
		'{red: 8'd255, green: 8'd85,  blue: 8'd85},
		'{red: 8'd255, green: 8'd85,  blue: 8'd255},
		'{red: 8'd255, green: 8'd255, blue: 8'd85},
		'{red: 8'd255, green: 8'd255, blue: 8'd255}
	};

	// absolute difference of two color components
	function automatic color_t abs_diff(input color_t a, input color_t b);
		color_t d;
		d = (a > b) ? (a - b) : (b - a);
		return d;
	endfunction

endpackage

[src/cga_pq_if.sv]
// ----------------------------------------------------------------------------
// cga palette quantizer stream interfaces
// pixel words in, palette index words out, valid/ready handshake
// ----------------------------------------------------------------------------

// pixel word channel
interface cga_pq_pixel_if;
	import cga_pq_pkg::*;

	logic   valid;
	logic   ready;
	color_t blue;
	color_t green;
	color_t red;

	modport source (output valid, output blue, output green, output red, input ready);
	modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

// palette index word channel
interface cga_pq_index_if;
	import cga_pq_pkg::*;

	logic   valid;
	logic   ready;
	index_t color_index;

	modport source (output valid, output color_index, input ready);
	modport sink   (input valid, input color_index, output ready);
endinterface

[src/cga_palette_quantizer_top.sv]
// Steps: differences, squares, leaf sums, then the comparison tree up to the root.
// Throughput: one pixel per cycle unless the output stalls; all entries are scored
// in parallel lanes and the argmin runs through a registered binary comparison
// tree, one level per stage. A stall at the output freezes all stages in place.
// Reset (arst_n low) clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// cga palette quantizer top level
// nearest-color search over the cga palette by squared euclidean distance
// ----------------------------------------------------------------------------
`include "cga_palette_quantizer_top_macros.svh"

module cga_palette_quantizer_top #(
	parameter int PALETTE_ENTRIES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	cga_pq_pixel_if.sink   pixel,
	cga_pq_index_if.source quant
);
	import cga_pq_pkg::*;

	localparam int LEVELS = $clog2(PALETTE_ENTRIES);
	localparam int LEAVES = 1 << LEVELS;
	localparam int STAGES = 3 + LEVELS;

	// stage valid bits and global advance
	logic [STAGES-1:0] vld_s;
	logic              adv;

	// stage 1: absolute differences, stage 2: squares
	color_t dr_s1 [PALETTE_ENTRIES];
	color_t dg_s1 [PALETTE_ENTRIES];
	color_t db_s1 [PALETTE_ENTRIES];
	sq_t    sr_s2 [PALETTE_ENTRIES];
	sq_t    sg_s2 [PALETTE_ENTRIES];
	sq_t    sb_s2 [PALETTE_ENTRIES];

	// comparison tree in heap order: node n holds min of nodes 2n and 2n+1,
	// leaves LEAVES..2*LEAVES-1 are stage 3, depth d is stage 3+LEVELS-d
	dist_t             tree_dist_s [1:2*LEAVES-1];
	logic [LEVELS-1:0] tree_idx_s  [1:2*LEAVES-1];

	// pipeline moves whenever the output register is empty or drained
	assign adv         = !vld_s[STAGES-1] || quant.ready;
	assign pixel.ready = adv;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[STAGES-2:0], pixel.valid};
		end
	end

	// per-entry lanes: difference and square
	for (genvar j = 0; j < PALETTE_ENTRIES; j++) begin : g_lane
		always_ff @(posedge clk) begin
			if (adv) begin
				dr_s1[j] <= abs_diff(pixel.red,   CGA_PALETTE[j].red);
				dg_s1[j] <= abs_diff(pixel.green, CGA_PALETTE[j].green);
				db_s1[j] <= abs_diff(pixel.blue,  CGA_PALETTE[j].blue);
				sr_s2[j] <= SQ_W'(dr_s1[j]) * SQ_W'(dr_s1[j]);
				sg_s2[j] <= SQ_W'(dg_s1[j]) * SQ_W'(dg_s1[j]);
				sb_s2[j] <= SQ_W'(db_s1[j]) * SQ_W'(db_s1[j]);
			end
		end
	end

	// tree leaves, absent entries score the largest distance
	for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
		always_ff @(posedge clk) begin
			if (adv) begin
				tree_idx_s[LEAVES+j] <= LEVELS'(j);
				if (j < PALETTE_ENTRIES) begin
					tree_dist_s[LEAVES+j] <= DIST_W'(sr_s2[j]) + DIST_W'(sg_s2[j])
						+ DIST_W'(sb_s2[j]);
				end else begin
					tree_dist_s[LEAVES+j] <= '1;
				end
			end
		end
	end

	// tree nodes, right child wins only when strictly nearer
	for (genvar n = 1; n < LEAVES; n++) begin : g_node
		always_ff @(posedge clk) begin
			if (adv) begin
				if (tree_dist_s[2*n+1] < tree_dist_s[2*n]) begin
					tree_dist_s[n] <= tree_dist_s[2*n+1];
					tree_idx_s[n]  <= tree_idx_s[2*n+1];
				end else begin
					tree_dist_s[n] <= tree_dist_s[2*n];
					tree_idx_s[n]  <= tree_idx_s[2*n];
				end
			end
		end
	end

	// result word from the tree root
	assign quant.valid       = vld_s[STAGES-1];
	assign quant.color_index = INDEX_W'(tree_idx_s[1]);

	// checks
	`CGA_PQ_ASSERT_NOW(a_index_range, quant.valid, quant.color_index < PALETTE_ENTRIES, "index beyond palette")
	`CGA_PQ_ASSERT_NOW(a_dist_below_start, quant.valid, tree_dist_s[1] < START_DIST, "winner not below start distance")
	`CGA_PQ_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld_s) && $stable(tree_idx_s[1]), "pipeline moved during stall")
	`CGA_PQ_ASSERT_NEXT(a_index_hold, quant.valid && !quant.ready, quant.valid && $stable(quant.color_index), "index word changed while waiting")

endmodule
